FILE: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define RHSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define RHSS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rhss_pkg.sv
`timescale 1ns / 1ps

package rhss_pkg;

    // Sizing (ring depth must stay a power of two)
    localparam int MAX_PATTERN   = 256;
    localparam int RING_AW       = $clog2(MAX_PATTERN);
    localparam int PLEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int POSITION_BITS = 16;
    localparam int HASH_W        = 64;
    localparam int SYM_W         = 8;
    localparam int FIFO_DEPTH    = 2;

    // Symbol bias: value is the signed byte minus 'a' - 1
    localparam logic signed [SYM_W+1:0] SYM_BIAS = 10'sd96;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2
    } t_opcode;

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        K_NOP,
        K_START,
        K_PATTERN,
        K_TEXT
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic                       last;
        logic                       hashed;
        logic                       check;
        logic                       need_sub;
        logic [POSITION_BITS-1:0]   start;
        logic [RING_AW-1:0]         raddr;
        logic [RING_AW-1:0]         waddr;
        logic [HASH_W-1:0]          prod;
    } t_job;

    // Multiply by the hash base 31 as shift and subtract
    function automatic logic [HASH_W-1:0] times_base(input logic [HASH_W-1:0] p);
        times_base = (p << 5) - p;
    endfunction

    // Symbol value times a power, modulo 2^64
    function automatic logic [HASH_W-1:0] sym_scale(input logic [HASH_W-1:0] p,
                                                    input logic [SYM_W-1:0] s);
        logic signed [SYM_W+1:0] v;
        logic [SYM_W-1:0]        mag;
        logic [HASH_W-1:0]       prd;
        v   = $signed({{2{s[SYM_W-1]}}, s}) - SYM_BIAS;
        mag = v[SYM_W+1] ? SYM_W'(-v) : SYM_W'(v);
        prd = HASH_W'(p * {{(HASH_W-SYM_W){1'b0}}, mag});
        sym_scale = v[SYM_W+1] ? (~prd + HASH_W'(1)) : prd;
    endfunction

endpackage

FILE: hdl/rhss_if.sv
`timescale 1ns / 1ps

// Request channel into the search block
interface rhss_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, opcode, symbol, last, input ready);
    modport sink   (input valid, opcode, symbol, last, output ready);
endinterface

// Result channel out of the search block
interface rhss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

FILE: hdl/rhss_front.sv
`timescale 1ns / 1ps

module rhss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_symbol,
    input  logic          i_last,
    input  logic          i_q_ready,
    output logic          o_push,
    output rhss_pkg::t_job o_job
);
    import rhss_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [PLEN_W-1:0]        r_plen, n_plen;
    logic [HASH_W-1:0]        r_ppow, n_ppow;
    logic [POSITION_BITS-1:0] r_tpos, n_tpos;
    logic [HASH_W-1:0]        r_tpow, n_tpow;
    logic [POSITION_BITS:0]   w_next_pos;
    logic [POSITION_BITS-1:0] w_plen_ext;

    assign o_push     = i_valid && i_q_ready;
    assign w_next_pos = {1'b0, r_tpos} + (POSITION_BITS+1)'(1);
    assign w_plen_ext = POSITION_BITS'(r_plen);

    // Classify the request and advance the counters
    always_comb begin
        n_plen = r_plen;
        n_ppow = r_ppow;
        n_tpos = r_tpos;
        n_tpow = r_tpow;
        o_job          = '0;
        o_job.kind     = K_NOP;
        o_job.last     = i_last;
        o_job.waddr    = r_tpos[RING_AW-1:0];
        o_job.raddr    = RING_AW'(r_tpos - w_plen_ext);
        o_job.start    = POSITION_BITS'(w_next_pos - {1'b0, w_plen_ext});
        o_job.need_sub = (o_job.start != '0);
        case (i_opcode)
            OP_START: begin
                o_job.kind = K_START;
                n_plen = '0;
                n_ppow = HASH_W'(1);
                n_tpos = '0;
                n_tpow = HASH_W'(1);
            end
            OP_PATTERN: begin
                if (r_tpos == '0 && r_plen < PLEN_W'(MAX_PATTERN)) begin
                    o_job.kind = K_PATTERN;
                    o_job.prod = sym_scale(r_ppow, i_symbol);
                    n_ppow = times_base(r_ppow);
                    n_plen = r_plen + PLEN_W'(1);
                end
            end
            OP_TEXT: begin
                o_job.kind   = K_TEXT;
                o_job.prod   = sym_scale(r_tpow, i_symbol);
                o_job.hashed = (r_tpos != POS_MAX);
                o_job.check  = o_job.hashed && (r_plen != '0)
                               && (w_next_pos >= {1'b0, w_plen_ext});
                if (o_job.hashed) begin
                    n_tpow = times_base(r_tpow);
                    n_tpos = w_next_pos[POSITION_BITS-1:0];
                end
            end
            default: begin
                o_job.kind = K_NOP;
            end
        endcase
    end

    // Counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_ppow <= HASH_W'(1);
            r_tpos <= '0;
            r_tpow <= HASH_W'(1);
        end else if (o_push) begin
            r_plen <= n_plen;
            r_ppow <= n_ppow;
            r_tpos <= n_tpos;
            r_tpow <= n_tpow;
        end
    end

endmodule

FILE: hdl/rhss_queue.sv
`timescale 1ns / 1ps

module rhss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rhss_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output rhss_pkg::t_job o_job
);
    import rhss_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_job               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [PTR_W:0]     r_count;
    logic               w_do_pop;

    assign o_ready  = (r_count != (PTR_W+1)'(FIFO_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_job    = r_mem[r_rptr];
    assign w_do_pop = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/rhss_back.sv
`timescale 1ns / 1ps

module rhss_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  rhss_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic [15:0]          o_position
);
    import rhss_pkg::*;

    typedef struct packed {
        t_kind                    kind;
        logic                     last;
        logic                     check;
        logic                     need_sub;
        logic [POSITION_BITS-1:0] start;
        logic [HASH_W-1:0]        prefix;
        logic [HASH_W-1:0]        phash;
    } t_s2;

    logic                 w_adv;
    logic                 r_s1_valid;
    t_job                 r_s1;
    logic                 r_s2_valid;
    t_s2                  r_s2;
    logic [HASH_W-1:0]    r_prefix;
    logic [HASH_W-1:0]    r_phash;
    logic [HASH_W-1:0]    r_target;
    logic                 r_done;
    logic [HASH_W-1:0]    r_ring [MAX_PATTERN];
    logic [HASH_W-1:0]    r_rdata;
    logic [HASH_W-1:0]    w_prefix;
    logic [HASH_W-1:0]    w_phash;
    logic                 w_wr;
    logic [HASH_W-1:0]    w_diff;
    logic                 w_hit;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [15:0]          r_out_pos;

    // Whole back pipe moves when the result register can take a value
    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv;

    // Stage 1: hash accumulate and ring access
    assign w_prefix = r_prefix + r_s1.prod;
    assign w_phash  = r_phash + r_s1.prod;
    assign w_wr     = r_s1_valid && (r_s1.kind == K_TEXT) && r_s1.hashed;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_wr) begin
                r_ring[r_s1.waddr] <= w_prefix;
            end
            r_rdata <= r_ring[r_s1.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_prefix   <= '0;
            r_phash    <= '0;
        end else if (w_adv) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                case (r_s1.kind)
                    K_START: begin
                        r_prefix <= '0;
                        r_phash  <= '0;
                    end
                    K_PATTERN: r_phash <= w_phash;
                    K_TEXT: begin
                        if (r_s1.hashed) begin
                            r_prefix <= w_prefix;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Stage registers carry no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1           <= i_job;
            r_s2.kind      <= r_s1.kind;
            r_s2.last      <= r_s1.last;
            r_s2.check     <= r_s1.check;
            r_s2.need_sub  <= r_s1.need_sub;
            r_s2.start     <= r_s1.start;
            r_s2.prefix    <= w_prefix;
            r_s2.phash     <= w_phash;
        end
    end

    // Stage 2: window compare, done tracking, result
    assign w_diff = r_s2.prefix - (r_s2.need_sub ? r_rdata : '0);
    assign w_hit  = r_s2.check && (w_diff == r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b0;
            if (r_s2_valid) begin
                case (r_s2.kind)
                    K_START: begin
                        r_done   <= 1'b0;
                        r_target <= '0;
                    end
                    K_PATTERN: r_target <= r_s2.phash;
                    K_TEXT: begin
                        if (!r_done) begin
                            if (w_hit) begin
                                r_done      <= 1'b1;
                                r_out_valid <= 1'b1;
                            end else begin
                                if (r_s2.check) begin
                                    r_target <= times_base(r_target);
                                end
                                if (r_s2.last) begin
                                    r_done      <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_found <= w_hit;
            r_out_pos   <= w_hit ? 16'(r_s2.start) : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule

FILE: hdl/rolling_hash_substring_search.sv
// Throughput: one request per cycle while the queue is not full.
// A 2-entry queue decouples intake from the hash pipe, which stalls while a result waits.
// The hash pipe is front multiply, prefix accumulate with ring access, then window compare.
// Reset: i_rst_n synchronous, active low; clears counters, hashes, done flag and valids.
// The prefix ring is not cleared; every read whose value is used hits an entry written in the same search.
`timescale 1ns / 1ps

module rolling_hash_substring_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhss_in_if.sink     i_in,
    rhss_out_if.source  o_out
);
    import rhss_pkg::*;

    logic  w_push;
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_pop;
    t_job  w_front_job;
    t_job  w_back_job;

    assign i_in.ready = w_q_ready;

    // Intake and classification
    rhss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_opcode  (i_in.opcode),
        .i_symbol  (i_in.symbol),
        .i_last    (i_in.last),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    // Decoupling queue
    rhss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_back_job)
    );

    // Hash pipe and result register
    rhss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_back_job),
        .o_pop      (w_pop),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_found    (o_out.found),
        .o_position (o_out.position)
    );

endmodule

FILE: hdl/rhss_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rhss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [15:0] i_position
);

    // Result held until taken
    `RHSS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")
    // Result payload stable while stalled
    `RHSS_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable({i_found, i_position}), "result changed")
    // A miss always reports start zero
    `RHSS_ASSERT(a_miss_zero, i_clk, i_rst_n, i_out_valid && !i_found |-> i_position == 16'd0, "miss with position")
    // No result right after reset
    `RHSS_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "result after reset")

endmodule

bind rolling_hash_substring_search rhss_checker u_rhss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_found     (o_out.found),
    .i_position  (o_out.position)
);
